### rtl/rfd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register map for the remote frame decoder.
// No dependencies; every other file of the block imports this package.
package rfd_pkg;

    localparam int FRAME_BYTES       = 18;
    localparam int IDX_W             = $clog2(FRAME_BYTES + 1);
    localparam int FRAME_QUEUE_DEPTH = 2;
    localparam int CFG_ADDR_W        = 5;
    localparam int CFG_DATA_W        = 32;

    localparam logic [IDX_W-1:0] IDX_IDLE = IDX_W'(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);

    localparam logic [10:0] CHANNEL_MIN_RESET   = 11'd364;
    localparam logic [10:0] CHANNEL_MAX_RESET   = 11'd1684;
    localparam logic [10:0] DEADBAND_LOW_RESET  = 11'd1020;
    localparam logic [10:0] DEADBAND_HIGH_RESET = 11'd1028;
    localparam logic [10:0] STICK_CENTRE_RESET  = 11'd1024;
    localparam logic [14:0] MOUSE_LIMIT_RESET   = 15'd25000;

    localparam logic [10:0] STICK_RESET    = 11'd1024;
    localparam logic [3:0]  SWITCHES_RESET = 4'hF;
    localparam logic [10:0] WHEEL_RESET    = 11'd1024;

    typedef enum logic [2:0] {
        REG_CHANNEL_MIN   = 3'd0,
        REG_CHANNEL_MAX   = 3'd1,
        REG_DEADBAND_LOW  = 3'd2,
        REG_DEADBAND_HIGH = 3'd3,
        REG_STICK_CENTRE  = 3'd4,
        REG_MOUSE_LIMIT   = 3'd5
    } reg_index_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic               frame_ok;
        logic [10:0]        stick_right_h;
        logic [10:0]        stick_right_v;
        logic [10:0]        stick_left_h;
        logic [10:0]        stick_left_v;
        logic [3:0]         switches;
        logic [10:0]        wheel;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        mouse_buttons;
        logic [15:0]        key_bits;
    } result_t;

    typedef struct packed {
        logic [10:0] channel_min;
        logic [10:0] channel_max;
        logic [10:0] deadband_low;
        logic [10:0] deadband_high;
        logic [10:0] stick_centre;
        logic [14:0] mouse_limit;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        frame_t bytes;
    } frame_beat_t;

endpackage

### rtl/rfd_cfg.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the remote frame decoder.
// Depends on rfd_pkg for the register map and the cfg_t bundle.
module rfd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rfd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output rfd_pkg::cfg_t                 cfg
);
    import rfd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    reg_index_t index;

    assign index  = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_CHANNEL_MIN:   cfg_next.channel_min   = pwdata[10:0];
                REG_CHANNEL_MAX:   cfg_next.channel_max   = pwdata[10:0];
                REG_DEADBAND_LOW:  cfg_next.deadband_low  = pwdata[10:0];
                REG_DEADBAND_HIGH: cfg_next.deadband_high = pwdata[10:0];
                REG_STICK_CENTRE:  cfg_next.stick_centre  = pwdata[10:0];
                REG_MOUSE_LIMIT:   cfg_next.mouse_limit   = pwdata[14:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_CHANNEL_MIN:   prdata = CFG_DATA_W'(cfg_reg.channel_min);
            REG_CHANNEL_MAX:   prdata = CFG_DATA_W'(cfg_reg.channel_max);
            REG_DEADBAND_LOW:  prdata = CFG_DATA_W'(cfg_reg.deadband_low);
            REG_DEADBAND_HIGH: prdata = CFG_DATA_W'(cfg_reg.deadband_high);
            REG_STICK_CENTRE:  prdata = CFG_DATA_W'(cfg_reg.stick_centre);
            REG_MOUSE_LIMIT:   prdata = CFG_DATA_W'(cfg_reg.mouse_limit);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_min   <= CHANNEL_MIN_RESET;
            cfg_reg.channel_max   <= CHANNEL_MAX_RESET;
            cfg_reg.deadband_low  <= DEADBAND_LOW_RESET;
            cfg_reg.deadband_high <= DEADBAND_HIGH_RESET;
            cfg_reg.stick_centre  <= STICK_CENTRE_RESET;
            cfg_reg.mouse_limit   <= MOUSE_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/rfd_front.sv
`timescale 1ns / 1ps
// Front end: takes frame bytes, tracks the byte position and collects a frame.
// Depends on rfd_pkg; hands complete frames to rfd_frame_queue.
module rfd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  rfd_pkg::item_t       item,
    output rfd_pkg::frame_beat_t frame_push
);
    import rfd_pkg::*;

    logic [IDX_W-1:0] byte_index_reg;
    logic [IDX_W-1:0] byte_index_next;
    frame_t           frame_bytes_reg;
    frame_t           frame_bytes_next;
    logic             accept;
    logic [IDX_W-1:0] idx;

    assign accept = push & ~full;
    assign idx    = item.frame_start ? '0 : byte_index_reg;

    always_comb
    begin
        byte_index_next  = byte_index_reg;
        frame_bytes_next = frame_bytes_reg;
        frame_push.valid = 1'b0;
        if (accept && idx < IDX_IDLE)
        begin
            frame_bytes_next[idx] = item.rx_byte;
            byte_index_next       = idx + 1'b1;
            frame_push.valid      = (idx == IDX_LAST);
        end
        frame_push.bytes = frame_bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= IDX_IDLE;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_bytes_reg <= frame_bytes_next;
    end

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= IDX_IDLE)
        else $error("byte index beyond frame length");

    a_push_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frame_push.valid |=> byte_index_reg == IDX_IDLE)
        else $error("frame handed on but index not back to idle");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.frame_start) |=> byte_index_reg == IDX_W'(1))
        else $error("start beat did not restart the frame");
`endif

endmodule

### rtl/rfd_frame_queue.sv
`timescale 1ns / 1ps
// Short queue of complete frames between the front end and the decoder.
// Depends on rfd_pkg for frame_t and frame_beat_t.
module rfd_frame_queue #(
    parameter int DEPTH = rfd_pkg::FRAME_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfd_pkg::frame_beat_t frame_push,
    input  logic                 frame_pop,
    output logic                 full,
    output rfd_pkg::frame_beat_t head
);
    import rfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.bytes = mem_reg[rd_ptr_reg];
    assign do_push    = frame_push.valid & ~full;
    assign do_pop     = frame_pop & head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= frame_push.bytes;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("frame queue count overflow");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        frame_push.valid |-> !full)
        else $error("frame pushed into full queue");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("frame queue count did not advance");
`endif

endmodule

### rtl/rfd_back.sv
`timescale 1ns / 1ps
// Back end: unpacks and checks a frame, updates the held values, drives results.
// Depends on rfd_pkg; takes frames from rfd_frame_queue and cfg from rfd_cfg.
module rfd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfd_pkg::cfg_t        cfg,
    input  rfd_pkg::frame_beat_t head,
    output logic                 frame_pop,
    input  logic                 pop,
    output logic                 empty,
    output rfd_pkg::result_t     result
);
    import rfd_pkg::*;

    logic [3:0][10:0]        held_sticks_reg;
    logic [3:0][10:0]        held_sticks_next;
    logic [3:0]              held_switches_reg;
    logic [3:0]              held_switches_next;
    logic [10:0]             held_wheel_reg;
    logic [10:0]             held_wheel_next;
    logic [2:0][15:0]        held_mouse_reg;
    logic [2:0][15:0]        held_mouse_next;
    logic [1:0][15:0]        held_keys_reg;
    logic [1:0][15:0]        held_keys_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_t                 result_reg;
    result_t                 result_next;

    frame_t                  f;
    logic [3:0][10:0]        ch;
    logic [1:0]              s_left;
    logic [1:0]              s_right;
    logic                    ok;

    function automatic logic [15:0] clamp_mouse(input logic [15:0] v,
                                                input logic [14:0] limit);
        logic signed [16:0] sv;
        logic signed [16:0] lim;
        logic signed [16:0] neg_lim;
        sv      = 17'($signed(v));
        lim     = $signed({2'b00, limit});
        neg_lim = -lim;
        if (sv > lim)
        begin
            return lim[15:0];
        end
        else if (sv < neg_lim)
        begin
            return neg_lim[15:0];
        end
        return v;
    endfunction

    assign f         = head.bytes;
    assign frame_pop = head.valid & (~out_valid_reg | pop);
    assign empty     = ~out_valid_reg;
    assign result    = result_reg;

    assign ch[0]   = {f[1][2:0], f[0]};
    assign ch[1]   = {f[2][5:0], f[1][7:3]};
    assign ch[2]   = {f[4][0], f[3], f[2][7:6]};
    assign ch[3]   = {f[5][3:0], f[4][7:1]};
    assign s_left  = f[5][7:6];
    assign s_right = f[5][5:4];

    always_comb
    begin
        ok = (s_left != 2'b00) && (s_right != 2'b00);
        for (int k = 0; k < 4; k++)
        begin
            if (ch[k] < cfg.channel_min || ch[k] > cfg.channel_max)
            begin
                ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        held_sticks_next   = held_sticks_reg;
        held_switches_next = held_switches_reg;
        held_wheel_next    = held_wheel_reg;
        held_mouse_next    = held_mouse_reg;
        held_keys_next     = held_keys_reg;
        if (frame_pop && ok)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (ch[k] > cfg.deadband_low && ch[k] < cfg.deadband_high)
                begin
                    held_sticks_next[k] = cfg.stick_centre;
                end
                else
                begin
                    held_sticks_next[k] = ch[k];
                end
            end
            held_switches_next = {s_left, s_right};
            held_wheel_next    = {f[17][2:0], f[16]};
            held_mouse_next[0] = clamp_mouse({f[7], f[6]}, cfg.mouse_limit);
            held_mouse_next[1] = clamp_mouse({f[9], f[8]}, cfg.mouse_limit);
            held_mouse_next[2] = {f[11], f[10]};
            held_keys_next[0]  = {f[13], f[12]};
            held_keys_next[1]  = {f[15], f[14]};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~pop;
        result_next    = result_reg;
        if (frame_pop)
        begin
            out_valid_next            = 1'b1;
            result_next.frame_ok      = ok;
            result_next.stick_right_h = held_sticks_next[0];
            result_next.stick_right_v = held_sticks_next[1];
            result_next.stick_left_h  = held_sticks_next[2];
            result_next.stick_left_v  = held_sticks_next[3];
            result_next.switches      = held_switches_next;
            result_next.wheel         = held_wheel_next;
            result_next.mouse_x       = $signed(held_mouse_next[0]);
            result_next.mouse_y       = $signed(held_mouse_next[1]);
            result_next.mouse_z       = $signed(held_mouse_next[2]);
            result_next.mouse_buttons = held_keys_next[0];
            result_next.key_bits      = held_keys_next[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_sticks_reg   <= {4{STICK_RESET}};
            held_switches_reg <= SWITCHES_RESET;
            held_wheel_reg    <= WHEEL_RESET;
            held_mouse_reg    <= '0;
            held_keys_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            held_sticks_reg   <= held_sticks_next;
            held_switches_reg <= held_switches_next;
            held_wheel_reg    <= held_wheel_next;
            held_mouse_reg    <= held_mouse_next;
            held_keys_reg     <= held_keys_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_switches_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.switches[3:2] != 2'b00) &&
                          (result_reg.switches[1:0] != 2'b00))
        else $error("result carries a zero switch");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pop |-> (!out_valid_reg || pop))
        else $error("frame taken while result slot occupied");

    a_result_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.wheel == held_wheel_reg) &&
                          (result_reg.stick_right_h == held_sticks_reg[0]) &&
                          (result_reg.key_bits == held_keys_reg[1]))
        else $error("waiting result differs from held values");
`endif

endmodule

### rtl/remote_frame_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the remote frame decoder: byte front end, frame queue, decoder.
// Depends on rfd_pkg, rfd_cfg, rfd_front, rfd_frame_queue and rfd_back.
//
// Usage:
//   Input channel (push/full) carries one frame byte per beat, with
//   frame_start marking byte 0. Bytes without a preceding start are dropped.
//   A start in mid frame drops the partial frame and restarts at byte 0.
//   Output channel (empty/pop) carries one result per complete 18-byte frame:
//   frame_ok plus the held stick, switch, wheel, mouse and key values.
//   Throughput: one byte per cycle while full is low. A finished frame
//   passes through the frame queue and the registered decoder stage to the
//   result ports. If pop stays low, finished frames collect in the frame
//   queue (QUEUE_DEPTH frames); full rises only once that queue is full.
//   Reset empties both sides, waits for a frame start, loads the default
//   registers and the default held values (sticks and wheel 1024, switches
//   15, mouse and keys zero). Registers are to be written over the APB port
//   only while idle; the block itself does not enforce this.
module remote_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = rfd_pkg::FRAME_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  rfd_pkg::item_t                 item,
    output logic                           empty,
    input  logic                           pop,
    output rfd_pkg::result_t               result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rfd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rfd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import rfd_pkg::*;

    cfg_t        cfg;
    frame_beat_t frame_push;
    frame_beat_t head;
    logic        frame_pop;

    rfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .frame_push (frame_push)
    );

    rfd_frame_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_push (frame_push),
        .frame_pop  (frame_pop),
        .full       (full),
        .head       (head)
    );

    rfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .frame_pop (frame_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
